/* src/survey_bearing_and_distance_defines.svh */
// Assertion macros for the survey bearing and distance block.
`ifndef SURVEY_BEARING_AND_DISTANCE_DEFINES_SVH
`define SURVEY_BEARING_AND_DISTANCE_DEFINES_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define SBD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define SBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/sbd_pkg.sv */
// Types, constants and CORDIC step functions for the survey bearing block.
package sbd_pkg;

  localparam int DATA_W    = 32;  // coordinate port and register width
  localparam int CFG_IDX_W = 3;
  localparam int VW        = 64;  // CORDIC datapath width
  localparam int NW        = 59;  // normalized magnitude, MSB at bit 58
  localparam int AW        = 32;  // angle as a fraction of a turn
  localparam int RANGE_W   = 33;
  localparam int BEAR_W    = 19;
  localparam int STAT_W    = 2;

  localparam logic [BEAR_W-1:0] MDEG_TURN = 19'd360000;
  localparam logic [AW-1:0]     ANG_HALF  = 32'h8000_0000;

  localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
  localparam logic [STAT_W-1:0] ST_TGT = 2'd1;
  localparam logic [STAT_W-1:0] ST_ORI = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIENT_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIENT_Y = 3'd3;

  localparam logic [AW-1:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic [VW-1:0] x;
    logic [VW-1:0] y;
    logic [NW-1:0] m;
    logic [AW-1:0] a;
  } vec_t;

  // Shift left by k when the top k bits of the magnitude are clear.
  function automatic vec_t nstep(input vec_t v, input int unsigned k);
    if ((v.m >> (NW - k)) == '0) begin
      v.m = v.m << k;
      v.x = v.x << k;
      v.y = v.y << k;
    end
    return v;
  endfunction

  // Fold the left half plane onto the right one.
  function automatic vec_t prerot(input vec_t v);
    if (v.x[VW-1]) begin
      v.x = -v.x;
      v.y = -v.y;
      v.a = ANG_HALF;
    end else begin
      v.a = '0;
    end
    return v;
  endfunction

  // One vectoring micro-rotation with floor shifts.
  function automatic vec_t crot(input vec_t v, input int unsigned i);
    logic signed [VW-1:0] xs;
    logic signed [VW-1:0] ys;
    logic [4:0]           ti;
    xs = $signed(v.x) >>> i;
    ys = $signed(v.y) >>> i;
    ti = i[4:0];
    if (!v.y[VW-1]) begin
      v.x = v.x + ys;
      v.y = v.y - xs;
      v.a = v.a + ATAN_TURNS[ti];
    end else begin
      v.x = v.x - ys;
      v.y = v.y + xs;
      v.a = v.a - ATAN_TURNS[ti];
    end
    return v;
  endfunction

endpackage

/* src/survey_bearing_and_distance.sv */
// Pipelined: each input item passes through every stage to a registered result item.
// Throughput: one item per cycle while out_stall is low; the CORDIC stage chain and the
// square-root digit chain (one result bit per stage) run side by side and set the depth.
// Empty stages fill while the output is stalled; in_stall rises only when all are full.
// Reset (rst_n low at a clock edge) clears all stage valids and the four registers to 0.
`include "survey_bearing_and_distance_defines.svh"

module survey_bearing_and_distance #(
  parameter int COORD_WIDTH   = 32,
  parameter int CORDIC_STAGES = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [sbd_pkg::DATA_W-1:0]    in_target_x,
  input  logic signed [sbd_pkg::DATA_W-1:0]    in_target_y,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic        [sbd_pkg::RANGE_W-1:0]   out_range_mm,
  output logic        [sbd_pkg::BEAR_W-1:0]    out_bearing_mdeg,
  output logic        [sbd_pkg::STAT_W-1:0]    out_status,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [sbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [sbd_pkg::DATA_W-1:0]    cfg_data
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 1;
  localparam int RW = CW + 1;
  localparam int SW = 2 * RW;
  localparam int HL = (CW + 1) / 2;
  localparam int HH = CW - HL;
  localparam int PW = sbd_pkg::AW + sbd_pkg::BEAR_W;
  localparam int EW = (RW + 1 > sbd_pkg::RANGE_W + 1) ? RW + 1 : sbd_pkg::RANGE_W + 1;

  localparam int J_DIF  = 1;
  localparam int J_ABS  = 2;
  localparam int J_PP   = 3;
  localparam int J_N1   = 4;
  localparam int J_N2   = 5;
  localparam int J_N3   = 6;
  localparam int J_ROT  = 7;
  localparam int J_CRD  = 8;
  localparam int J_MUL  = J_CRD + CORDIC_STAGES;
  localparam int J_FIN  = J_MUL + 1;
  localparam int J_SQ0  = 5;
  localparam int J_RND  = J_SQ0 + RW;
  localparam int L      = (J_FIN > J_RND) ? J_FIN : J_RND;

  typedef struct packed {
    logic                          tz;
    logic                          oz;
    sbd_pkg::vec_t                 tv;
    sbd_pkg::vec_t                 ov;
    logic [CW-1:0]                 tax;
    logic [CW-1:0]                 tay;
    logic [CW-1:0]                 oax;
    logic [CW-1:0]                 oay;
    logic [2*HH-1:0]               pxh;
    logic [2*HH-1:0]               pyh;
    logic [HH+HL-1:0]              pxm;
    logic [HH+HL-1:0]              pym;
    logic [2*HL-1:0]               pxl;
    logic [2*HL-1:0]               pyl;
    logic [SW-1:0]                 sq;
    logic [RW+1:0]                 rem;
    logic [RW-1:0]                 root;
    logic [PW-1:0]                 prod;
    logic [sbd_pkg::RANGE_W-1:0]   rng;
    logic [sbd_pkg::BEAR_W-1:0]    bearing;
    logic [sbd_pkg::STAT_W-1:0]    status;
  } stg_t;

  function automatic logic signed [DW-1:0] crd(input logic [sbd_pkg::DATA_W-1:0] v);
    logic signed [CW-1:0] w;
    w = CW'(v);
    return DW'(w);
  endfunction

  function automatic logic [CW-1:0] mag(input logic [sbd_pkg::VW-1:0] v);
    return v[sbd_pkg::VW-1] ? CW'(-v) : CW'(v);
  endfunction

  logic [sbd_pkg::DATA_W-1:0] base_x_r, base_y_r, orient_x_r, orient_y_r;
  logic signed [DW-1:0]       dtx, dty, dox, doy;
  logic [L:1]                 vld_r;
  logic [L+1:1]               en;
  stg_t                       stg_r   [1:L];
  stg_t                       stg_nxt [1:L];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_x_r   <= '0;
      base_y_r   <= '0;
      orient_x_r <= '0;
      orient_y_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sbd_pkg::REG_BASE_X:   base_x_r   <= cfg_data;
        sbd_pkg::REG_BASE_Y:   base_y_r   <= cfg_data;
        sbd_pkg::REG_ORIENT_X: orient_x_r <= cfg_data;
        sbd_pkg::REG_ORIENT_Y: orient_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign dtx = crd(in_target_x) - crd(base_x_r);
  assign dty = crd(in_target_y) - crd(base_y_r);
  assign dox = crd(orient_x_r)  - crd(base_x_r);
  assign doy = crd(orient_y_r)  - crd(base_y_r);

  // Stage enables: a stage loads when it is empty or the one after it moves.
  assign en[L+1]  = !out_stall;
  assign in_stall = !en[1];

  genvar j;
  for (j = 1; j <= L; j++) begin : g_stg
    localparam int P  = (j > 1) ? j - 1 : 1;
    localparam int CI = (j >= J_CRD && j < J_MUL) ? j - J_CRD : 0;

    assign en[j] = !vld_r[j] || en[j+1];

    always_comb begin
      logic [RW+3:0]             t4;
      logic [RW+3:0]             trial;
      logic [EW-1:0]             rsum;
      logic [PW:0]               bsum;
      logic [sbd_pkg::BEAR_W-1:0] b;
      t4    = '0;
      trial = '0;
      rsum  = '0;
      bsum  = '0;
      b     = '0;
      if (j == 1) stg_nxt[j] = '0;
      else        stg_nxt[j] = stg_r[P];

      if (j == J_DIF) begin
        stg_nxt[j].tv.x = sbd_pkg::VW'(dtx);
        stg_nxt[j].tv.y = sbd_pkg::VW'(dty);
        stg_nxt[j].ov.x = sbd_pkg::VW'(dox);
        stg_nxt[j].ov.y = sbd_pkg::VW'(doy);
      end
      if (j == J_ABS) begin
        stg_nxt[j].tax = mag(stg_r[P].tv.x);
        stg_nxt[j].tay = mag(stg_r[P].tv.y);
        stg_nxt[j].oax = mag(stg_r[P].ov.x);
        stg_nxt[j].oay = mag(stg_r[P].ov.y);
        stg_nxt[j].tz  = (stg_r[P].tv.x == '0) && (stg_r[P].tv.y == '0);
        stg_nxt[j].oz  = (stg_r[P].ov.x == '0) && (stg_r[P].ov.y == '0);
      end
      if (j == J_PP) begin
        stg_nxt[j].tv.m = sbd_pkg::NW'((stg_r[P].tax > stg_r[P].tay) ?
                                       stg_r[P].tax : stg_r[P].tay);
        stg_nxt[j].ov.m = sbd_pkg::NW'((stg_r[P].oax > stg_r[P].oay) ?
                                       stg_r[P].oax : stg_r[P].oay);
        stg_nxt[j].pxh = (2*HH)'(stg_r[P].tax[CW-1:HL]) * (2*HH)'(stg_r[P].tax[CW-1:HL]);
        stg_nxt[j].pyh = (2*HH)'(stg_r[P].tay[CW-1:HL]) * (2*HH)'(stg_r[P].tay[CW-1:HL]);
        stg_nxt[j].pxm = (HH+HL)'(stg_r[P].tax[CW-1:HL]) * (HH+HL)'(stg_r[P].tax[HL-1:0]);
        stg_nxt[j].pym = (HH+HL)'(stg_r[P].tay[CW-1:HL]) * (HH+HL)'(stg_r[P].tay[HL-1:0]);
        stg_nxt[j].pxl = (2*HL)'(stg_r[P].tax[HL-1:0]) * (2*HL)'(stg_r[P].tax[HL-1:0]);
        stg_nxt[j].pyl = (2*HL)'(stg_r[P].tay[HL-1:0]) * (2*HL)'(stg_r[P].tay[HL-1:0]);
      end
      if (j == J_N1) begin
        stg_nxt[j].sq = (SW'(stg_r[P].pxh) << (2*HL)) + (SW'(stg_r[P].pxm) << (HL+1)) +
                        SW'(stg_r[P].pxl) +
                        (SW'(stg_r[P].pyh) << (2*HL)) + (SW'(stg_r[P].pym) << (HL+1)) +
                        SW'(stg_r[P].pyl);
        stg_nxt[j].rem  = '0;
        stg_nxt[j].root = '0;
        stg_nxt[j].tv = sbd_pkg::nstep(sbd_pkg::nstep(stg_r[P].tv, 32), 16);
        stg_nxt[j].ov = sbd_pkg::nstep(sbd_pkg::nstep(stg_r[P].ov, 32), 16);
      end
      if (j == J_N2) begin
        stg_nxt[j].tv = sbd_pkg::nstep(sbd_pkg::nstep(stg_r[P].tv, 8), 4);
        stg_nxt[j].ov = sbd_pkg::nstep(sbd_pkg::nstep(stg_r[P].ov, 8), 4);
      end
      if (j == J_N3) begin
        stg_nxt[j].tv = sbd_pkg::nstep(sbd_pkg::nstep(stg_r[P].tv, 2), 1);
        stg_nxt[j].ov = sbd_pkg::nstep(sbd_pkg::nstep(stg_r[P].ov, 2), 1);
      end
      if (j == J_ROT) begin
        stg_nxt[j].tv = sbd_pkg::prerot(stg_r[P].tv);
        stg_nxt[j].ov = sbd_pkg::prerot(stg_r[P].ov);
      end
      if (j >= J_CRD && j < J_MUL) begin
        stg_nxt[j].tv = sbd_pkg::crot(stg_r[P].tv, CI);
        stg_nxt[j].ov = sbd_pkg::crot(stg_r[P].ov, CI);
      end
      if (j == J_MUL) begin
        // wrap the angle difference to one turn before widening
        stg_nxt[j].prod = PW'(sbd_pkg::AW'(stg_r[P].ov.a - stg_r[P].tv.a)) *
                          PW'(sbd_pkg::MDEG_TURN);
      end
      if (j == J_FIN) begin
        bsum = (PW+1)'(stg_r[P].prod) + (PW+1)'(sbd_pkg::ANG_HALF);
        b    = sbd_pkg::BEAR_W'(bsum >> sbd_pkg::AW);
        // a full turn after rounding wraps to zero
        if (b >= sbd_pkg::MDEG_TURN) b = '0;
        if (stg_r[P].oz) begin
          stg_nxt[j].status  = sbd_pkg::ST_ORI;
          stg_nxt[j].bearing = '0;
        end else if (stg_r[P].tz) begin
          stg_nxt[j].status  = sbd_pkg::ST_TGT;
          stg_nxt[j].bearing = '0;
        end else begin
          stg_nxt[j].status  = sbd_pkg::ST_OK;
          stg_nxt[j].bearing = b;
        end
      end
      // Restoring square root: one root bit per stage.
      if (j >= J_SQ0 && j < J_RND) begin
        t4    = {stg_r[P].rem, stg_r[P].sq[SW-1:SW-2]};
        trial = (RW+4)'({stg_r[P].root, 2'b01});
        if (t4 >= trial) begin
          stg_nxt[j].rem  = (RW+2)'(t4 - trial);
          stg_nxt[j].root = {stg_r[P].root[RW-2:0], 1'b1};
        end else begin
          stg_nxt[j].rem  = (RW+2)'(t4);
          stg_nxt[j].root = {stg_r[P].root[RW-2:0], 1'b0};
        end
        stg_nxt[j].sq = stg_r[P].sq << 2;
      end
      if (j == J_RND) begin
        // round up when the remainder exceeds the root, then clamp
        rsum = EW'(stg_r[P].root) +
               EW'((stg_r[P].rem > (RW+2)'(stg_r[P].root)) ? 1'b1 : 1'b0);
        if (rsum > EW'({sbd_pkg::RANGE_W{1'b1}})) stg_nxt[j].rng = '1;
        else stg_nxt[j].rng = rsum[sbd_pkg::RANGE_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en[j]) begin
        vld_r[j] <= (j == 1) ? in_valid : vld_r[P];
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        stg_r[j] <= stg_nxt[j];
      end
    end
  end

  assign out_valid        = vld_r[L];
  assign out_range_mm     = stg_r[L].rng;
  assign out_bearing_mdeg = stg_r[L].bearing;
  assign out_status       = stg_r[L].status;

  `SBD_ASSERT_NOW(a_flag_no_bearing, out_valid && (out_status != sbd_pkg::ST_OK),
                  out_bearing_mdeg == '0, "bearing set on flagged item")
  `SBD_ASSERT_NOW(a_bearing_range, out_valid, out_bearing_mdeg < sbd_pkg::MDEG_TURN,
                  "bearing beyond one turn")
  `SBD_ASSERT_NOW(a_tgt_zero_range, out_valid && (out_status == sbd_pkg::ST_TGT),
                  out_range_mm == '0, "target on base with range")
  `SBD_ASSERT_NOW(a_stall_full, in_stall, &vld_r, "input stalled with an empty stage")
  `SBD_ASSERT_NEXT(a_take, in_valid && !in_stall, vld_r[1], "accepted item lost at entry")

endmodule
